/* rtl/hps_pkg.sv */
package hps_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned TempW   = 2;
  localparam int unsigned ElapsedW = 16;

  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_LOCK   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FLOW_TMO   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ON_LOCK    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_HOLD = 3'd4;

  localparam logic [ModeW-1:0] MODE_COOLDOWN   = 3'd0;
  localparam logic [ModeW-1:0] MODE_OFF_LOCKED = 3'd1;
  localparam logic [ModeW-1:0] MODE_OFF        = 3'd2;
  localparam logic [ModeW-1:0] MODE_FLOW_CHECK = 3'd3;
  localparam logic [ModeW-1:0] MODE_ON_LOCKED  = 3'd4;
  localparam logic [ModeW-1:0] MODE_ON         = 3'd5;
  localparam logic [ModeW-1:0] MODE_ERROR      = 3'd6;
  localparam logic [ModeW-1:0] MODE_FATAL      = 3'd7;

  localparam logic [TempW-1:0] TEMP_BELOW = 2'd0;
  localparam logic [TempW-1:0] TEMP_ABOVE = 2'd2;

  localparam int unsigned RLY_COMP = 0;
  localparam int unsigned RLY_PRI  = 1;
  localparam int unsigned RLY_SEC  = 2;
  localparam logic [2:0] RLY_ALL_OFF = 3'b111;

  localparam logic [CfgW-1:0] COOLDOWN_RST   = 16'd60;
  localparam logic [CfgW-1:0] OFF_LOCK_RST   = 16'd300;
  localparam logic [CfgW-1:0] FLOW_TMO_RST   = 16'd30;
  localparam logic [CfgW-1:0] ON_LOCK_RST    = 16'd300;
  localparam logic [CfgW-1:0] ERROR_HOLD_RST = 16'd600;

  typedef struct packed {
    logic [TempW-1:0] temp_level;
    logic             flow_ok;
    logic             measure_ok;
  } in_item_t;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic                compressor_off;
    logic                primary_pump_off;
    logic                secondary_pump_off;
    logic                halted;
    logic [ElapsedW-1:0] elapsed;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] cooldown_period;
    logic [CfgW-1:0] off_lock_period;
    logic [CfgW-1:0] flow_timeout;
    logic [CfgW-1:0] on_lock_period;
    logic [CfgW-1:0] error_hold_period;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [2:0]       relays;
    logic             halt;
  } seq_state_t;

endpackage

/* rtl/hps_if.sv */
interface hps_in_if;
  logic               valid;
  logic               ready;
  hps_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hps_out_if;
  logic               valid;
  logic               ready;
  hps_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/hps_cfg_regs.sv */
module hps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hps_pkg::CfgW-1:0]      cfg_data_i,
  output hps_pkg::cfg_t                 cfg_o
);

  hps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cooldown_period   <= hps_pkg::COOLDOWN_RST;
      cfg_q.off_lock_period   <= hps_pkg::OFF_LOCK_RST;
      cfg_q.flow_timeout      <= hps_pkg::FLOW_TMO_RST;
      cfg_q.on_lock_period    <= hps_pkg::ON_LOCK_RST;
      cfg_q.error_hold_period <= hps_pkg::ERROR_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hps_pkg::CFG_COOLDOWN:   cfg_q.cooldown_period   <= cfg_data_i;
        hps_pkg::CFG_OFF_LOCK:   cfg_q.off_lock_period   <= cfg_data_i;
        hps_pkg::CFG_FLOW_TMO:   cfg_q.flow_timeout      <= cfg_data_i;
        hps_pkg::CFG_ON_LOCK:    cfg_q.on_lock_period    <= cfg_data_i;
        hps_pkg::CFG_ERROR_HOLD: cfg_q.error_hold_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/hps_step.sv */
module hps_step #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  hps_pkg::seq_state_t    state_i,
  input  logic [TIMER_BITS-1:0]  timer_i,
  input  hps_pkg::in_item_t      item_i,
  input  hps_pkg::cfg_t          cfg_i,
  output hps_pkg::seq_state_t    state_o,
  output logic [TIMER_BITS-1:0]  timer_o
);

  localparam int unsigned CmpW =
    (TIMER_BITS > hps_pkg::CfgW) ? TIMER_BITS : hps_pkg::CfgW;

  logic [TIMER_BITS-1:0] tick;
  logic [CmpW-1:0]       t;
  logic                  below;
  logic                  above;

  always_comb begin
    tick  = (timer_i == {TIMER_BITS{1'b1}}) ? timer_i : timer_i + TIMER_BITS'(1);
    t     = CmpW'(tick);
    below = (item_i.temp_level == hps_pkg::TEMP_BELOW);
    above = (item_i.temp_level == hps_pkg::TEMP_ABOVE);

    state_o = state_i;
    timer_o = timer_i;

    if (!state_i.halt) begin
      timer_o = tick;
      if (item_i.measure_ok) begin
        unique case (state_i.mode)
          hps_pkg::MODE_COOLDOWN: begin
            if (t > CmpW'(cfg_i.cooldown_period)) begin
              state_o.relays[hps_pkg::RLY_PRI] = 1'b1;
              state_o.relays[hps_pkg::RLY_SEC] = 1'b1;
              state_o.mode = hps_pkg::MODE_OFF_LOCKED;
            end
          end
          hps_pkg::MODE_OFF_LOCKED: begin
            if (t > CmpW'(cfg_i.off_lock_period)) begin
              state_o.mode = hps_pkg::MODE_OFF;
            end
          end
          hps_pkg::MODE_OFF: begin
            if (below) begin
              state_o.mode = hps_pkg::MODE_FLOW_CHECK;
              state_o.relays[hps_pkg::RLY_PRI] = 1'b0;
              state_o.relays[hps_pkg::RLY_SEC] = 1'b0;
              timer_o = '0;
            end
            if (item_i.flow_ok) begin
              state_o.mode = hps_pkg::MODE_ERROR;
              timer_o = '0;
            end
          end
          hps_pkg::MODE_FLOW_CHECK: begin
            if (t < CmpW'(cfg_i.flow_timeout)) begin
              if (item_i.flow_ok) begin
                state_o.relays[hps_pkg::RLY_COMP] = 1'b0;
                state_o.mode = hps_pkg::MODE_ON_LOCKED;
                timer_o = '0;
              end
            end else begin
              state_o.mode = hps_pkg::MODE_ERROR;
              timer_o = '0;
            end
          end
          hps_pkg::MODE_ON_LOCKED: begin
            if (t > CmpW'(cfg_i.on_lock_period)) begin
              state_o.mode = hps_pkg::MODE_ON;
            end
            if (!item_i.flow_ok) begin
              state_o.relays = hps_pkg::RLY_ALL_OFF;
              state_o.mode = hps_pkg::MODE_OFF_LOCKED;
            end
          end
          hps_pkg::MODE_ON: begin
            if (above) begin
              state_o.mode = hps_pkg::MODE_COOLDOWN;
              state_o.relays[hps_pkg::RLY_COMP] = 1'b1;
              timer_o = '0;
            end
            if (!item_i.flow_ok) begin
              state_o.relays = hps_pkg::RLY_ALL_OFF;
              state_o.mode = hps_pkg::MODE_OFF_LOCKED;
            end
          end
          hps_pkg::MODE_ERROR: begin
            if (t > CmpW'(cfg_i.error_hold_period)) begin
              state_o.mode = hps_pkg::MODE_OFF_LOCKED;
            end
            state_o.relays = hps_pkg::RLY_ALL_OFF;
          end
          default: begin
            state_o.halt = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/heat_pump_sequencer.sv */
// Heat pump sequencer, stepped once per input transaction (one second tick).
// Each transaction carries the tank temperature class, the flow flag and the
// measurement flag, and yields exactly one result transaction with the mode,
// the three active-low relay drives, the halted flag and the event timer
// (saturated at 65535 on the output). A transaction is registered, stepped
// through the sequencer and written to the result register once the result
// side can take it, and one transaction is taken every cycle while the
// result side keeps up; the sequencer state register closes the loop from
// one transaction to the next. Configuration writes are registered and must
// only be issued while no transaction is in flight.
module heat_pump_sequencer #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hps_pkg::CfgW-1:0]    cfg_data_i,
  hps_in_if.sink                      in_i,
  hps_out_if.source                   out_o
);

  localparam int unsigned WideW =
    (TIMER_BITS > hps_pkg::ElapsedW) ? TIMER_BITS : hps_pkg::ElapsedW;

  hps_pkg::cfg_t       cfg;
  hps_pkg::in_item_t   in_item_q;
  logic                in_vld_q;
  hps_pkg::out_item_t  out_item_q;
  hps_pkg::out_item_t  out_item_d;
  logic                out_vld_q;
  hps_pkg::seq_state_t state_q;
  hps_pkg::seq_state_t state_d;
  logic [TIMER_BITS-1:0] timer_q;
  logic [TIMER_BITS-1:0] timer_d;
  logic [WideW-1:0]    timer_wide;
  logic                advance;

  hps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hps_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .state_i (state_q),
    .timer_i (timer_q),
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .timer_o (timer_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_comb begin
    timer_wide = WideW'(timer_d);
    out_item_d.mode               = state_d.mode;
    out_item_d.compressor_off     = state_d.relays[hps_pkg::RLY_COMP];
    out_item_d.primary_pump_off   = state_d.relays[hps_pkg::RLY_PRI];
    out_item_d.secondary_pump_off = state_d.relays[hps_pkg::RLY_SEC];
    out_item_d.halted             = state_d.halt;
    out_item_d.elapsed = (timer_wide > WideW'({hps_pkg::ElapsedW{1'b1}})) ?
                         {hps_pkg::ElapsedW{1'b1}} :
                         timer_wide[hps_pkg::ElapsedW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode   <= hps_pkg::MODE_OFF_LOCKED;
      state_q.relays <= hps_pkg::RLY_ALL_OFF;
      state_q.halt   <= 1'b0;
      timer_q        <= '0;
      out_vld_q      <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
        timer_q <= timer_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_item_q;

endmodule

/* rtl/hps_checker.sv */
module hps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input hps_pkg::out_item_t out_data_i
);

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_data_i.halted) begin
      seen_halt_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_halt_q |-> out_data_i.halted)
    else $error("halted flag cleared after halt");

  a_comp_on_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.compressor_off |->
      (out_data_i.mode == hps_pkg::MODE_ON_LOCKED) ||
      (out_data_i.mode == hps_pkg::MODE_ON))
    else $error("compressor energized outside on modes");

  a_off_relays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_data_i.mode == hps_pkg::MODE_OFF_LOCKED) ||
                    (out_data_i.mode == hps_pkg::MODE_OFF)) |->
      out_data_i.compressor_off && out_data_i.primary_pump_off &&
      out_data_i.secondary_pump_off)
    else $error("relay energized in off mode");

endmodule

bind heat_pump_sequencer hps_checker u_hps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

/* tb/tb_top.sv */
module tb_top;

  localparam int unsigned TimerW = 16;
  localparam int unsigned PhaseItems = 115;
  localparam int unsigned Phases = 12;
  localparam int unsigned ClimbItems = 40;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned LongHold = 40;
  localparam logic [hps_pkg::TempW-1:0] TEMP_WITHIN = 2'd1;
  localparam logic [hps_pkg::TempW-1:0] TEMP_CODE3 = 2'd3;
  localparam logic [hps_pkg::CfgIdxW-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [hps_pkg::CfgIdxW-1:0] CFG_UNUSED_HI = 3'd7;

  class mode_scoreboard;
    logic [hps_pkg::CfgW-1:0] cooldown_s, off_lock_s, flow_tmo_s, on_lock_s, err_hold_s;
    logic [hps_pkg::ModeW-1:0] mode;
    logic [TimerW-1:0] seconds;
    logic [2:0] relays;
    logic halt;
    hps_pkg::out_item_t expected_q[$];
    int errors;

    function new();
      cooldown_s = hps_pkg::COOLDOWN_RST;
      off_lock_s = hps_pkg::OFF_LOCK_RST;
      flow_tmo_s = hps_pkg::FLOW_TMO_RST;
      on_lock_s = hps_pkg::ON_LOCK_RST;
      err_hold_s = hps_pkg::ERROR_HOLD_RST;
      mode = hps_pkg::MODE_OFF_LOCKED;
      seconds = '0;
      relays = hps_pkg::RLY_ALL_OFF;
      halt = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [hps_pkg::CfgIdxW-1:0] idx, logic [hps_pkg::CfgW-1:0] val);
      case (idx)
        hps_pkg::CFG_COOLDOWN: cooldown_s = val;
        hps_pkg::CFG_OFF_LOCK: off_lock_s = val;
        hps_pkg::CFG_FLOW_TMO: flow_tmo_s = val;
        hps_pkg::CFG_ON_LOCK: on_lock_s = val;
        hps_pkg::CFG_ERROR_HOLD: err_hold_s = val;
        default: ;
      endcase
    endfunction

    function void note_tick(hps_pkg::in_item_t it);
      logic [TimerW-1:0] t;
      hps_pkg::out_item_t want;
      if (!halt) begin
        if (seconds != '1) seconds = seconds + TimerW'(1);
        if (it.measure_ok) begin
          t = seconds;
          case (mode)
            hps_pkg::MODE_COOLDOWN: begin
              if (t > cooldown_s) begin
                relays[hps_pkg::RLY_PRI] = 1'b1;
                relays[hps_pkg::RLY_SEC] = 1'b1;
                mode = hps_pkg::MODE_OFF_LOCKED;
              end
            end
            hps_pkg::MODE_OFF_LOCKED: begin
              if (t > off_lock_s) mode = hps_pkg::MODE_OFF;
            end
            hps_pkg::MODE_OFF: begin
              if (it.temp_level == hps_pkg::TEMP_BELOW) begin
                mode = hps_pkg::MODE_FLOW_CHECK;
                relays[hps_pkg::RLY_PRI] = 1'b0;
                relays[hps_pkg::RLY_SEC] = 1'b0;
                seconds = '0;
              end
              if (it.flow_ok) begin
                mode = hps_pkg::MODE_ERROR;
                seconds = '0;
              end
            end
            hps_pkg::MODE_FLOW_CHECK: begin
              if (t < flow_tmo_s) begin
                if (it.flow_ok) begin
                  relays[hps_pkg::RLY_COMP] = 1'b0;
                  mode = hps_pkg::MODE_ON_LOCKED;
                  seconds = '0;
                end
              end else begin
                mode = hps_pkg::MODE_ERROR;
                seconds = '0;
              end
            end
            hps_pkg::MODE_ON_LOCKED: begin
              if (t > on_lock_s) mode = hps_pkg::MODE_ON;
              if (!it.flow_ok) begin
                relays = hps_pkg::RLY_ALL_OFF;
                mode = hps_pkg::MODE_OFF_LOCKED;
              end
            end
            hps_pkg::MODE_ON: begin
              if (it.temp_level == hps_pkg::TEMP_ABOVE) begin
                mode = hps_pkg::MODE_COOLDOWN;
                relays[hps_pkg::RLY_COMP] = 1'b1;
                seconds = '0;
              end
              if (!it.flow_ok) begin
                relays = hps_pkg::RLY_ALL_OFF;
                mode = hps_pkg::MODE_OFF_LOCKED;
              end
            end
            hps_pkg::MODE_ERROR: begin
              if (t > err_hold_s) mode = hps_pkg::MODE_OFF_LOCKED;
              relays = hps_pkg::RLY_ALL_OFF;
            end
            default: halt = 1'b1;
          endcase
        end
      end
      want.mode = mode;
      want.compressor_off = relays[hps_pkg::RLY_COMP];
      want.primary_pump_off = relays[hps_pkg::RLY_PRI];
      want.secondary_pump_off = relays[hps_pkg::RLY_SEC];
      want.halted = halt;
      want.elapsed = seconds[hps_pkg::ElapsedW-1:0];
      expected_q.push_back(want);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(hps_pkg::out_item_t got);
      hps_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("compressor_off", want.compressor_off, got.compressor_off);
        check_field("primary_pump_off", want.primary_pump_off, got.primary_pump_off);
        check_field("secondary_pump_off", want.secondary_pump_off, got.secondary_pump_off);
        check_field("halted", want.halted, got.halted);
        check_field("elapsed", want.elapsed, got.elapsed);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hps_pkg::CfgIdxW-1:0] cfg_idx;
  logic [hps_pkg::CfgW-1:0] cfg_data;
  bit idle_on;
  bit long_hold_pending;
  int unsigned items_sent;
  int unsigned results_seen;
  mode_scoreboard sb = new();

  hps_in_if in_if();
  hps_out_if out_if();

  heat_pump_sequencer #(.TIMER_BITS(TimerW)) u_top (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i(in_if),
    .out_o(out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_tick(in_if.data);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.data);
      results_seen++;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_pending = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  task automatic send_tick(hps_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_fields(logic [hps_pkg::TempW-1:0] temp, logic flow, logic meas);
    hps_pkg::in_item_t it;
    it.temp_level = temp;
    it.flow_ok = flow;
    it.measure_ok = meas;
    send_tick(it);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic put_reg(logic [hps_pkg::CfgIdxW-1:0] idx, logic [hps_pkg::CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(hps_pkg::cfg_t c);
    put_reg(hps_pkg::CFG_COOLDOWN, c.cooldown_period);
    put_reg(hps_pkg::CFG_OFF_LOCK, c.off_lock_period);
    put_reg(hps_pkg::CfgIdxW'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
            hps_pkg::CfgW'($urandom));
    put_reg(hps_pkg::CFG_FLOW_TMO, c.flow_timeout);
    put_reg(hps_pkg::CFG_ON_LOCK, c.on_lock_period);
    put_reg(hps_pkg::CFG_ERROR_HOLD, c.error_hold_period);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [hps_pkg::CfgW-1:0] rand_period();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return hps_pkg::CfgW'($urandom_range(1, 12));
  endfunction

  initial begin
    hps_pkg::cfg_t c;
    hps_pkg::in_item_t it;
    int unsigned flow_pct;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    idle_on = 1'b1;
    long_hold_pending = 1'b0;
    items_sent = 0;
    results_seen = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_fields(TEMP_CODE3, 1'b1, 1'b1);
    send_fields(hps_pkg::TEMP_BELOW, 1'b0, 1'b0);
    send_fields(hps_pkg::TEMP_ABOVE, 1'b1, 1'b1);
    wait_idle();
    c = '{cooldown_period: '0, off_lock_period: '0, flow_timeout: hps_pkg::CfgW'(2),
          on_lock_period: '0, error_hold_period: '0};
    load_config(c);
    send_fields(TEMP_WITHIN, 1'b1, 1'b1);
    send_fields(TEMP_CODE3, 1'b0, 1'b1);
    send_fields(hps_pkg::TEMP_BELOW, 1'b0, 1'b0);
    send_fields(hps_pkg::TEMP_BELOW, 1'b0, 1'b1);
    send_fields(TEMP_WITHIN, 1'b1, 1'b1);
    send_fields(hps_pkg::TEMP_ABOVE, 1'b1, 1'b1);
    send_fields(TEMP_CODE3, 1'b1, 1'b1);
    send_fields(hps_pkg::TEMP_ABOVE, 1'b1, 1'b1);
    send_fields(TEMP_WITHIN, 1'b1, 1'b1);
    send_fields(TEMP_WITHIN, 1'b0, 1'b1);
    send_fields(hps_pkg::TEMP_BELOW, 1'b1, 1'b1);
    send_fields(TEMP_WITHIN, 1'b1, 1'b1);
    send_fields(TEMP_WITHIN, 1'b0, 1'b1);
    send_fields(hps_pkg::TEMP_BELOW, 1'b0, 1'b1);
    repeat (3) send_fields(TEMP_WITHIN, 1'b0, 1'b1);
    send_fields(TEMP_WITHIN, 1'b0, 1'b1);
    send_fields(TEMP_WITHIN, 1'b0, 1'b1);
    send_fields(hps_pkg::TEMP_BELOW, 1'b0, 1'b1);
    send_fields(hps_pkg::TEMP_BELOW, 1'b1, 1'b1);
    send_fields(hps_pkg::TEMP_ABOVE, 1'b0, 1'b1);

    for (int ph = 0; ph < Phases; ph++) begin
      wait_idle();
      if (ph == 0) c = '0;
      else if (ph == 1) c = '1;
      else c = '{rand_period(), rand_period(), rand_period(), rand_period(), rand_period()};
      load_config(c);
      idle_on = (ph < Phases - 2);
      if (ph == 4) long_hold_pending = 1'b1;
      case (ph % 3)
        0: flow_pct = 95;
        1: flow_pct = 80;
        default: flow_pct = 50;
      endcase
      repeat (PhaseItems) begin
        it.temp_level = hps_pkg::TempW'($urandom_range(0, 3));
        it.flow_ok = ($urandom_range(0, 99) < flow_pct);
        it.measure_ok = ($urandom_range(0, 9) != 0);
        send_tick(it);
      end
    end

    // let the timer climb with unmeasured ticks, then step from there
    wait_idle();
    c = '{rand_period(), rand_period(), rand_period(), rand_period(), rand_period()};
    load_config(c);
    idle_on = 1'b0;
    repeat (ClimbItems) begin
      it.temp_level = hps_pkg::TempW'($urandom_range(0, 3));
      it.flow_ok = 1'($urandom_range(0, 1));
      it.measure_ok = 1'b0;
      send_tick(it);
    end
    repeat (20) begin
      it.temp_level = hps_pkg::TempW'($urandom_range(0, 3));
      it.flow_ok = 1'($urandom_range(0, 1));
      it.measure_ok = 1'($urandom_range(0, 1));
      send_tick(it);
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hps_pkg.sv
rtl/hps_if.sv
rtl/hps_cfg_regs.sv
rtl/hps_step.sv
rtl/heat_pump_sequencer.sv
rtl/hps_checker.sv
tb/tb_top.sv
